// ===== rtl/ffpa_pkg.sv =====
// Shared constants for the first-fit page allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

   localparam int MAX_PAGES_DEF  = 256;
   localparam int OWNER_BITS_DEF = 16;

   localparam int PAGE_SIZE_W  = 17;
   localparam int PAGE_COUNT_W = 9;
   localparam int BYTES_W      = 32;
   localparam int CNT_OUT_W    = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 17;

   localparam logic [PAGE_SIZE_W-1:0]  PAGE_SIZE_RST  = 17'd4096;
   localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 1'b1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

endpackage

// ===== rtl/ffpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ffpa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/first_fit_page_allocator.sv =====
// First-fit page-frame allocator: top level with page table RAM and request sequencer.
`timescale 1ns / 1ps

// Allocates and releases page frames held in one page-table RAM (owned bit plus
// owner id per frame). After reset the block sweeps the table once to mark every
// frame free, with req_ready low throughout the sweep; configuration writes are
// accepted throughout. A granted allocate first runs a 32-step restoring divider
// to work out the pages needed, then one pass over the table counts free frames
// and a second pass claims them, each pass limited by the single RAM read port
// (one frame per cycle) and ending once the last read has drained. A refused
// allocate skips the claim pass. A release makes one pass over the whole table.
// One request is worked on at a time, and the block is back in idle before the
// next item is taken; the finished result sits in an output register, so the
// next request can be taken while it waits, and a result still waiting there
// when the next one is ready stalls the block.

module first_fit_page_allocator #(
   parameter int MAX_PAGES  = ffpa_pkg::MAX_PAGES_DEF,
   parameter int OWNER_BITS = ffpa_pkg::OWNER_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ffpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ffpa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [OWNER_BITS-1:0]              req_owner_id,
   input  logic [ffpa_pkg::BYTES_W-1:0]       req_memory_required,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_granted,
   output logic [ffpa_pkg::CNT_OUT_W-1:0]     rsp_pages_changed,
   output logic [ffpa_pkg::CNT_OUT_W-1:0]     rsp_used_pages
);

   localparam int IDX_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_W    = $clog2(MAX_PAGES + 1);
   localparam int ENTRY_W  = OWNER_BITS + 1;
   localparam int BYTES_W  = ffpa_pkg::BYTES_W;
   localparam int PS_W     = ffpa_pkg::PAGE_SIZE_W;
   localparam int STEP_W   = $clog2(BYTES_W);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_DIV     = 3'd2;
   localparam logic [2:0] ST_COUNT   = 3'd3;
   localparam logic [2:0] ST_CLAIM   = 3'd4;
   localparam logic [2:0] ST_RELEASE = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   logic [2:0]                          state_ff, state_in;
   logic [CNT_W-1:0]                    scan_ff, scan_in;
   logic [CNT_W-1:0]                    end_ff, end_in;
   logic                                pend_ff, pend_in;
   logic [IDX_W-1:0]                    pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]                    free_ff, free_in;
   logic [CNT_W-1:0]                    changed_ff, changed_in;
   logic [CNT_W-1:0]                    used_ff, used_in;
   logic                                ok_ff, ok_in;
   logic [BYTES_W-1:0]                  div_ff, div_in;
   logic [PS_W-1:0]                     rem_ff, rem_in;
   logic [PS_W-1:0]                     ps_ff, ps_in;
   logic [STEP_W-1:0]                   step_ff, step_in;
   logic [OWNER_BITS-1:0]               owner_ff, owner_in;
   logic [PS_W-1:0]                     page_size_ff, page_size_in;
   logic [ffpa_pkg::PAGE_COUNT_W-1:0]   page_count_ff, page_count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_granted_ff, rsp_granted_in;
   logic [ffpa_pkg::CNT_OUT_W-1:0]      rsp_changed_ff, rsp_changed_in;
   logic [ffpa_pkg::CNT_OUT_W-1:0]      rsp_used_ff, rsp_used_in;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   logic                entry_owned;
   logic                entry_match;
   logic                issue;
   logic                scanning;
   logic [PS_W:0]       div_shift;
   logic [PS_W:0]       div_diff;
   logic                div_ge;
   logic [PS_W-1:0]     rem_next;
   logic [BYTES_W-1:0]  quo_next;
   logic [CNT_W-1:0]    limit;

   ffpa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_pages_changed = rsp_changed_ff;
   assign rsp_used_pages    = rsp_used_ff;

   assign entry_owned = ram_rd_data[OWNER_BITS];
   assign entry_match = entry_owned && (ram_rd_data[OWNER_BITS-1:0] == owner_ff);
   assign issue       = (scan_ff != end_ff);
   assign scanning    = (state_ff == ST_COUNT) || (state_ff == ST_CLAIM) ||
                        (state_ff == ST_RELEASE);

   // One restoring division step: quotient bits shift into div_ff.
   assign div_shift = {rem_ff, div_ff[BYTES_W-1]};
   assign div_diff  = div_shift - {1'b0, ps_ff};
   assign div_ge    = (div_shift >= {1'b0, ps_ff});
   assign rem_next  = div_ge ? div_diff[PS_W-1:0] : div_shift[PS_W-1:0];
   assign quo_next  = {div_ff[BYTES_W-2:0], div_ge};

   always_comb begin
      if (32'(page_count_ff) > 32'(MAX_PAGES)) begin
         limit = CNT_W'(MAX_PAGES);
      end else begin
         limit = CNT_W'(page_count_ff);
      end
   end

   // Configuration registers.
   always_comb begin
      page_size_in  = page_size_ff;
      page_count_in = page_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ffpa_pkg::CSR_PAGE_SIZE: begin
               page_size_in = csr_wdata[PS_W-1:0];
            end
            ffpa_pkg::CSR_PAGE_COUNT: begin
               page_count_in = csr_wdata[ffpa_pkg::PAGE_COUNT_W-1:0];
            end
            default: begin
               page_size_in = page_size_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      end_in         = end_ff;
      pend_in        = 1'b0;
      pend_addr_in   = pend_addr_ff;
      free_in        = free_ff;
      changed_in     = changed_ff;
      used_in        = used_ff;
      ok_in          = ok_ff;
      div_in         = div_ff;
      rem_in         = rem_ff;
      ps_in          = ps_ff;
      step_in        = step_ff;
      owner_in       = owner_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_used_in    = rsp_used_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pend_addr_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = scan_ff[IDX_W-1:0];

      // Table passes: read one frame a cycle, act on the frame read last cycle.
      if (scanning) begin
         ram_rd_en    = issue;
         pend_in      = issue;
         pend_addr_in = scan_ff[IDX_W-1:0];
         if (issue) begin
            scan_in = scan_ff + CNT_W'(1);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = scan_ff[IDX_W-1:0];
            scan_in     = scan_ff + CNT_W'(1);
            if (scan_ff == CNT_W'(MAX_PAGES - 1)) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               owner_in   = req_owner_id;
               changed_in = '0;
               free_in    = '0;
               scan_in    = '0;
               ok_in      = 1'b1;
               if (req_op == ffpa_pkg::OP_RELEASE) begin
                  end_in   = CNT_W'(MAX_PAGES);
                  state_in = ST_RELEASE;
               end else begin
                  div_in   = req_memory_required;
                  rem_in   = '0;
                  step_in  = '0;
                  ps_in    = (page_size_ff == '0) ? PS_W'(1) : page_size_ff;
                  end_in   = limit;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(BYTES_W - 1)) begin
               // Round up: a nonzero remainder needs one more page.
               div_in   = quo_next + BYTES_W'(rem_next != '0);
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (pend_ff && !entry_owned) begin
               free_in = free_ff + CNT_W'(1);
            end
            if (!issue && !pend_ff) begin
               if (div_ff > BYTES_W'(free_ff)) begin
                  ok_in    = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  scan_in  = '0;
                  state_in = ST_CLAIM;
               end
            end
         end
         ST_CLAIM: begin
            if (pend_ff && !entry_owned && (BYTES_W'(changed_ff) < div_ff)) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b1, owner_ff};
               changed_in  = changed_ff + CNT_W'(1);
            end
            if (!issue && !pend_ff) begin
               used_in  = used_ff + changed_ff;
               state_in = ST_DONE;
            end
         end
         ST_RELEASE: begin
            if (pend_ff && entry_match) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b0, ram_rd_data[OWNER_BITS-1:0]};
               changed_in  = changed_ff + CNT_W'(1);
            end
            if (!issue && !pend_ff) begin
               used_in  = used_ff - changed_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = ok_ff;
               rsp_changed_in = ffpa_pkg::CNT_OUT_W'(changed_ff);
               rsp_used_in    = ffpa_pkg::CNT_OUT_W'(used_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            scan_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         page_size_ff  <= ffpa_pkg::PAGE_SIZE_RST;
         page_count_ff <= ffpa_pkg::PAGE_COUNT_RST;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         pend_ff       <= pend_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         page_size_ff  <= page_size_in;
         page_count_ff <= page_count_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff         <= end_in;
      pend_addr_ff   <= pend_addr_in;
      free_ff        <= free_in;
      changed_ff     <= changed_in;
      ok_ff          <= ok_in;
      div_ff         <= div_in;
      rem_ff         <= rem_in;
      ps_ff          <= ps_in;
      step_ff        <= step_in;
      owner_ff       <= owner_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_used_ff    <= rsp_used_in;
   end

endmodule

// ===== rtl/ffpa_checker.sv =====
// Port-level assertions for the first-fit page allocator, bound to the top level.
`timescale 1ns / 1ps

module ffpa_checker #(
   parameter int OWNER_BITS = ffpa_pkg::OWNER_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_op,
   input logic [OWNER_BITS-1:0]           req_owner_id,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_granted,
   input logic [ffpa_pkg::CNT_OUT_W-1:0]  rsp_pages_changed,
   input logic [ffpa_pkg::CNT_OUT_W-1:0]  rsp_used_pages
);

   // Reset starts the table sweep: no item taken, no result shown.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("ready or result valid right after reset");

   // One item at a time: ready drops once an item is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted back to back");

   // A waiting item holds its op and owner id.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_op) &&
         $stable(req_owner_id)))
      else $error("request changed while waiting");

   // A failed allocation changes no page.
   a_fail_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_pages_changed == '0))
      else $error("failed allocation reports changed pages");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_granted) &&
         $stable(rsp_pages_changed) && $stable(rsp_used_pages)))
      else $error("result changed while stalled");

endmodule

bind first_fit_page_allocator ffpa_checker #(
   .OWNER_BITS (OWNER_BITS)
) u_ffpa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_op            (req_op),
   .req_owner_id      (req_owner_id),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_granted       (rsp_granted),
   .rsp_pages_changed (rsp_pages_changed),
   .rsp_used_pages    (rsp_used_pages)
);

// ===== tb/tb_first_fit_page_allocator.sv =====
// Self-checking testbench for the first-fit page allocator.
`timescale 1ns / 1ps

module tb_first_fit_page_allocator;

   localparam int FRAMES      = ffpa_pkg::MAX_PAGES_DEF;
   localparam int OWNER_W     = ffpa_pkg::OWNER_BITS_DEF;
   localparam int BYTES_W     = ffpa_pkg::BYTES_W;
   localparam int CNT_OUT_W   = ffpa_pkg::CNT_OUT_W;
   localparam int CSR_IDX_W   = ffpa_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = ffpa_pkg::CSR_DATA_W;
   localparam int PS_W        = ffpa_pkg::PAGE_SIZE_W;
   localparam int PC_W        = ffpa_pkg::PAGE_COUNT_W;
   localparam int OWNER_POOL  = 8;
   localparam int TAIL_CYCLES = 600;

   typedef struct packed {
      logic               op;
      logic [OWNER_W-1:0] owner;
      logic [BYTES_W-1:0] bytes;
   } page_req_type;

   typedef struct packed {
      logic                 granted;
      logic [CNT_OUT_W-1:0] changed;
      logic [CNT_OUT_W-1:0] used;
   } page_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_op = ffpa_pkg::OP_ALLOC;
   logic [OWNER_W-1:0]      req_owner_id = '0;
   logic [BYTES_W-1:0]      req_memory_required = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_granted;
   logic [CNT_OUT_W-1:0]    rsp_pages_changed;
   logic [CNT_OUT_W-1:0]    rsp_used_pages;

   page_req_type pending_requests[$];
   page_rsp_type expected_results[$];

   // frame table mirror and register copies
   bit                      frame_owned[FRAMES];
   logic [OWNER_W-1:0]      frame_owner[FRAMES];
   int unsigned             frames_in_use = 0;
   logic [PS_W-1:0]         cur_page_size = ffpa_pkg::PAGE_SIZE_RST;
   logic [PC_W-1:0]         cur_page_count = ffpa_pkg::PAGE_COUNT_RST;

   logic [OWNER_W-1:0]      owner_pool[OWNER_POOL];
   bit                      calm = 1'b0;
   bit                      req_took = 1'b0;
   int unsigned             mismatches = 0;
   int unsigned             n_checked = 0;
   int unsigned             n_alloc_ok = 0;
   int unsigned             n_alloc_refused = 0;
   int unsigned             n_release = 0;
   int unsigned             n_settings = 1;

   first_fit_page_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_owner_id        (req_owner_id),
      .req_memory_required (req_memory_required),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted         (rsp_granted),
      .rsp_pages_changed   (rsp_pages_changed),
      .rsp_used_pages      (rsp_used_pages)
   );

   always #1 clock = ~clock;

   // Work out the result of one request and update the frame table mirror.
   function automatic page_rsp_type allocate_or_release(page_req_type r);
      page_rsp_type     res;
      longint unsigned  divisor;
      longint unsigned  wanted;
      longint unsigned  free_frames;
      longint unsigned  byte_cnt;
      int unsigned      span;
      int unsigned      claimed;
      res.granted = 1'b1;
      claimed = 0;
      if (r.op == ffpa_pkg::OP_ALLOC) begin
         divisor = (cur_page_size == 0) ? 1 : cur_page_size;
         byte_cnt = r.bytes;
         wanted = (byte_cnt + divisor - 1) / divisor;
         span = (cur_page_count > FRAMES) ? FRAMES : cur_page_count;
         free_frames = 0;
         for (int i = 0; i < span; i++)
            if (!frame_owned[i]) free_frames++;
         if (wanted > free_frames) begin
            res.granted = 1'b0;
            n_alloc_refused++;
         end else begin
            for (int i = 0; i < span && claimed < wanted; i++) begin
               if (!frame_owned[i]) begin
                  frame_owned[i] = 1'b1;
                  frame_owner[i] = r.owner;
                  claimed++;
               end
            end
            frames_in_use += claimed;
            n_alloc_ok++;
         end
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            if (frame_owned[i] && frame_owner[i] == r.owner) begin
               frame_owned[i] = 1'b0;
               claimed++;
            end
         end
         frames_in_use -= claimed;
         n_release++;
      end
      res.changed = claimed[CNT_OUT_W-1:0];
      res.used = frames_in_use[CNT_OUT_W-1:0];
      return res;
   endfunction

   // Mostly page-sized allocations and releases from a small set of owners,
   // with some oversized requests and unknown owners mixed in.
   function automatic page_req_type random_request();
      page_req_type    r;
      int unsigned     pick;
      longint unsigned unit;
      unit = (cur_page_size == 0) ? 1 : cur_page_size;
      pick = $urandom_range(0, 99);
      r.op = ffpa_pkg::OP_ALLOC;
      r.owner = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
      if (pick < 62) begin
         r.bytes = $urandom_range(0, 12 * unit);
      end else if (pick < 68) begin
         r.bytes = $urandom_range(0, 64 * unit);
      end else if (pick < 93) begin
         r.op = ffpa_pkg::OP_RELEASE;
         r.bytes = $urandom();
      end else if (pick < 97) begin
         r.op = ffpa_pkg::OP_RELEASE;
         r.owner = OWNER_W'($urandom());
         r.bytes = $urandom();
      end else begin
         r.owner = OWNER_W'($urandom());
         r.bytes = $urandom();
      end
      return r;
   endfunction

   task automatic queue_request(input logic op, input logic [OWNER_W-1:0] owner,
                                input logic [BYTES_W-1:0] bytes);
      page_req_type r;
      r.op = op;
      r.owner = owner;
      r.bytes = bytes;
      pending_requests = {pending_requests, r};
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == ffpa_pkg::CSR_PAGE_SIZE)
         cur_page_size = value;
      else
         cur_page_count = value[PC_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until the sender is empty and every result has come back.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic run_phase(input logic [PS_W-1:0] size,
                            input logic [PC_W-1:0] count,
                            input int n, input bit no_idle);
      wait_for_drain();
      write_csr(ffpa_pkg::CSR_PAGE_SIZE, size);
      write_csr(ffpa_pkg::CSR_PAGE_COUNT, {{(CSR_DATA_W - PC_W){1'b0}}, count});
      n_settings++;
      @(posedge clock);
      calm = no_idle;
      repeat (n) pending_requests = {pending_requests, random_request()};
   endtask

   // driver: a new item only once the previous one is taken
   always @(negedge clock) begin : driver
      page_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
            nxt = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_op <= nxt.op;
            req_owner_id <= nxt.owner;
            req_memory_required <= nxt.bytes;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && (calm || $urandom_range(0, 99) >= 23);
   end

   always @(posedge clock) begin : monitor
      page_req_type seen;
      page_rsp_type want;
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_took = 1'b1;
            seen.op = req_op;
            seen.owner = req_owner_id;
            seen.bytes = req_memory_required;
            expected_results = {expected_results, allocate_or_release(seen)};
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result granted=%0d changed=%0d used=%0d",
                        $time, rsp_granted, rsp_pages_changed, rsp_used_pages);
            end else begin
               want = expected_results.pop_front();
               n_checked++;
               if (rsp_granted !== want.granted) begin
                  mismatches++;
                  $display("%0t: granted expected %0d actual %0d",
                           $time, want.granted, rsp_granted);
               end
               if (rsp_pages_changed !== want.changed) begin
                  mismatches++;
                  $display("%0t: pages_changed expected %0d actual %0d",
                           $time, want.changed, rsp_pages_changed);
               end
               if (rsp_used_pages !== want.used) begin
                  mismatches++;
                  $display("%0t: used_pages expected %0d actual %0d",
                           $time, want.used, rsp_used_pages);
               end
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         frame_owned[i] = 1'b0;
         frame_owner[i] = '0;
      end
      owner_pool[0] = '0;
      owner_pool[1] = '1;
      for (int i = 2; i < OWNER_POOL; i++)
         owner_pool[i] = OWNER_W'($urandom());

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, at the reset settings of 4096-byte pages over 256 frames
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0000, 32'd0);
      queue_request(ffpa_pkg::OP_ALLOC, 16'hFFFF, 32'd1);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0000, 32'd4096);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0000, 32'd4097);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0001, 32'hFFFF_FFFF);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0002, 32'd250 * 32'd4096);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0003, 32'd3 * 32'd4096);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0003, 32'd2 * 32'd4096 - 32'd1);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0004, 32'd1);
      queue_request(ffpa_pkg::OP_RELEASE, 16'hFFFF, 32'd0);
      queue_request(ffpa_pkg::OP_RELEASE, 16'h1234, 32'hFFFF_FFFF);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0004, 32'd1);
      queue_request(ffpa_pkg::OP_RELEASE, 16'h0002, 32'd0);
      queue_request(ffpa_pkg::OP_RELEASE, 16'h0000, 32'd0);
      queue_request(ffpa_pkg::OP_RELEASE, 16'h0003, 32'd0);
      queue_request(ffpa_pkg::OP_RELEASE, 16'h0004, 32'd0);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0005, 32'd256 * 32'd4096);
      queue_request(ffpa_pkg::OP_RELEASE, 16'h0005, 32'd0);
      queue_request(ffpa_pkg::OP_ALLOC, 16'h0006, 32'd256 * 32'd4096 + 32'd1);

      // random part; each phase first drains, which also stalls the sender
      run_phase(17'd4096, 9'd256, 180, 1'b1);
      run_phase(17'd1, 9'd256, 130, 1'b0);
      run_phase(17'd65536, 9'd0, 60, 1'b0);
      run_phase(17'd0, 9'd511, 130, 1'b0);
      run_phase(17'd65536, 9'd256, 110, 1'b0);
      run_phase(PS_W'($urandom_range(1, 65536)), PC_W'($urandom_range(1, 255)), 130, 1'b0);
      run_phase(17'd512, 9'd32, 130, 1'b0);
      run_phase(17'd4096, 9'd256, 280, 1'b0);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d results checked over %0d register settings", n_checked, n_settings);
      $display("%0d allocations granted, %0d refused, %0d releases",
               n_alloc_ok, n_alloc_refused, n_release);
      if (mismatches == 0) begin
         $display("** first_fit_page_allocator: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** first_fit_page_allocator: FAILED **");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("** first_fit_page_allocator: FAILED **");
      $finish;
   end

endmodule
